@@ rtl/core/variable_interval_low_pass_defines.svh @@
// Assertion macros for the variable interval low-pass filter.
// VILP_ASSERT expects the module to have i_clk and i_rst_n; VILP_ASSERT_ALWAYS needs only i_clk.
`ifndef VARIABLE_INTERVAL_LOW_PASS_DEFINES_SVH
`define VARIABLE_INTERVAL_LOW_PASS_DEFINES_SVH

`ifndef SYNTHESIS

`define VILP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

`define VILP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("assertion failed");

`else

`define VILP_ASSERT(lbl, prop)

`define VILP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/core/vilp_pkg.sv @@
package vilp_pkg;

    localparam int ALPHA_FRAC_BITS = 24;
    localparam int EXTRA_FRAC_BITS = 8;
    localparam int VALUE_W = 32;
    localparam int TIME_W = 48;
    localparam int TAU_W = 27;
    localparam int DT_W = 32;
    localparam int DEN_W = DT_W + 2;
    localparam int STATE_W = VALUE_W + EXTRA_FRAC_BITS;
    localparam int DIFF_W = STATE_W + 1;
    localparam int ACC_W = DIFF_W + ALPHA_FRAC_BITS;
    localparam int CNT_W = $clog2(ALPHA_FRAC_BITS);
    localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'(60000);

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DT,
        S_DEN,
        S_DIV,
        S_DIFF,
        S_MUL,
        S_UPD,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/vilp_addsub.sv @@
module vilp_addsub (
    input  vilp_pkg::t_alu_op            i_op,
    input  logic [vilp_pkg::ACC_W-1:0]   i_a,
    input  logic [vilp_pkg::ACC_W-1:0]   i_b,
    output logic [vilp_pkg::ACC_W-1:0]   o_sum
);
    import vilp_pkg::*;

    logic [ACC_W-1:0] b_eff;
    logic             carry_in;

    always_comb begin
        case (i_op)
            ALU_SUB: begin
                b_eff    = ~i_b;
                carry_in = 1'b1;
            end
            default: begin
                b_eff    = i_b;
                carry_in = 1'b0;
            end
        endcase
    end

    assign o_sum = i_a + b_eff + ACC_W'(carry_in);

endmodule

@@ rtl/core/variable_interval_low_pass.sv @@
// First-order low-pass filter for timestamped Q16.16 samples at uneven intervals.
// One item is taken at a time: i_in_valid with o_in_stall low starts it, and
// o_in_stall stays high until its result has been taken on the output channel.
// The first item of a series, the first item after reset, and every item while
// the time constant is zero pass straight through, with the result offered in
// the cycle after the item is taken. Any other item goes through timestamp
// difference, divisor setup, 24 divide steps, difference, 24 multiply steps and
// state update before its result is offered, all on one shared 65-bit adder that
// forms alpha one quotient bit per cycle and the weighted step one multiplier bit
// per cycle. The user must write the time constant register only while no item
// is in flight; the block itself does not enforce this. o_cfg_ready is always high.
`include "variable_interval_low_pass_defines.svh"

module variable_interval_low_pass (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vilp_pkg::TAU_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [vilp_pkg::TIME_W-1:0]         i_sample_time_ms,
    input  logic signed [vilp_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                                i_series_start,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [vilp_pkg::VALUE_W-1:0] o_filtered_value
);
    import vilp_pkg::*;

    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [TAU_W-1:0]              r_tau;
    logic                          r_have, n_have;
    logic [TIME_W-1:0]             r_last, n_last;
    logic [TIME_W-1:0]             r_time, n_time;
    logic signed [STATE_W-1:0]     r_target, n_target;
    logic signed [STATE_W-1:0]     r_fstate, n_fstate;
    logic [DT_W-1:0]               r_dt, n_dt;
    logic [DEN_W-1:0]              r_den, n_den;
    logic [DEN_W-1:0]              r_rem, n_rem;
    logic [ALPHA_FRAC_BITS-1:0]    r_alpha, n_alpha;
    logic signed [DIFF_W-1:0]      r_diff, n_diff;
    logic signed [ACC_W-1:0]       r_acc, n_acc;

    t_alu_op                       alu_op;
    logic [ACC_W-1:0]              alu_a, alu_b, alu_sum;
    logic [DEN_W-1:0]              rem_shift;
    logic                          in_accept;
    logic signed [STATE_W-1:0]     in_target;

    vilp_addsub u_addsub (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign in_accept        = i_in_valid && !o_in_stall;
    assign o_out_valid      = (r_state == S_OUT);
    assign o_filtered_value = r_fstate[STATE_W-1:EXTRA_FRAC_BITS];
    assign in_target        = {i_sample_value, {EXTRA_FRAC_BITS{1'b0}}};
    assign rem_shift        = {r_rem[DEN_W-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tau    <= TAU_RESET;
            r_have   <= 1'b0;
            r_last   <= '0;
            r_fstate <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_have   <= n_have;
            r_last   <= n_last;
            r_fstate <= n_fstate;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tau <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_time   <= n_time;
        r_target <= n_target;
        r_dt     <= n_dt;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_alpha  <= n_alpha;
        r_diff   <= n_diff;
        r_acc    <= n_acc;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_have   = r_have;
        n_last   = r_last;
        n_time   = r_time;
        n_target = r_target;
        n_fstate = r_fstate;
        n_dt     = r_dt;
        n_den    = r_den;
        n_rem    = r_rem;
        n_alpha  = r_alpha;
        n_diff   = r_diff;
        n_acc    = r_acc;
        alu_op   = ALU_ADD;
        alu_a    = '0;
        alu_b    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_time   = i_sample_time_ms;
                    n_target = in_target;
                    n_have   = 1'b1;
                    if (i_series_start || !r_have || (r_tau == '0)) begin
                        n_fstate = in_target;
                        n_last   = i_sample_time_ms;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_DT;
                    end
                end
            end
            S_DT: begin
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(r_time);
                alu_b  = ACC_W'(r_last);
                if (alu_sum[ACC_W-1]) begin
                    n_dt = '0;
                end else if (|alu_sum[TIME_W-1:DT_W]) begin
                    n_dt = '1;
                end else begin
                    n_dt = alu_sum[DT_W-1:0];
                end
                n_last  = r_time;
                n_state = S_DEN;
            end
            S_DEN: begin
                alu_op  = ALU_ADD;
                alu_a   = ACC_W'(r_dt);
                alu_b   = ACC_W'(r_tau);
                n_den   = alu_sum[DEN_W-1:0];
                n_rem   = DEN_W'(r_dt);
                n_alpha = '0;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = ACC_W'(rem_shift);
                alu_b  = ACC_W'(r_den);
                if (alu_sum[ACC_W-1]) begin
                    n_rem   = rem_shift;
                    n_alpha = {r_alpha[ALPHA_FRAC_BITS-2:0], 1'b0};
                end else begin
                    n_rem   = alu_sum[DEN_W-1:0];
                    n_alpha = {r_alpha[ALPHA_FRAC_BITS-2:0], 1'b1};
                end
                if (r_cnt == CNT_W'(ALPHA_FRAC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIFF: begin
                alu_op  = ALU_SUB;
                alu_a   = ACC_W'(r_target);
                alu_b   = ACC_W'(r_fstate);
                n_diff  = alu_sum[DIFF_W-1:0];
                n_acc   = '0;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                alu_op  = ALU_ADD;
                alu_a   = r_acc <<< 1;
                alu_b   = r_alpha[ALPHA_FRAC_BITS-1] ? ACC_W'(r_diff) : '0;
                n_acc   = alu_sum;
                n_alpha = {r_alpha[ALPHA_FRAC_BITS-2:0], 1'b0};
                if (r_cnt == CNT_W'(ALPHA_FRAC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_UPD: begin
                alu_op   = ALU_ADD;
                alu_a    = ACC_W'(r_fstate);
                alu_b    = r_acc >>> ALPHA_FRAC_BITS;
                n_fstate = alu_sum[STATE_W-1:0];
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The partial remainder always stays below the divisor.
    `VILP_ASSERT(a_rem_below_den, (r_state == S_DIV) |-> (r_rem < r_den))
    `VILP_ASSERT(a_cnt_range, (r_state == S_DIV || r_state == S_MUL) |->
        (r_cnt < CNT_W'(ALPHA_FRAC_BITS)))
    `VILP_ASSERT(a_no_accept_with_result, in_accept |-> !o_out_valid)
    `VILP_ASSERT(a_result_after_sample, o_out_valid |-> r_have)

endmodule
